// ===== rtl/diff_run_image_decoder_top_defines.svh =====
// Assertion macros for the differential run image decoder.
// Depends on nothing; included by the top level.
`ifndef DIFF_RUN_IMAGE_DECODER_TOP_DEFINES_SVH
`define DIFF_RUN_IMAGE_DECODER_TOP_DEFINES_SVH
// Immediate implication checked at every clock edge outside reset.
`define DRID_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked at every clock edge outside reset.
`define DRID_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/drid_pkg.sv =====
// Shared types and constants of the differential run image decoder.
// Depends on nothing; imported by every module of the block.
`default_nettype none
package drid_pkg;
  localparam int CountWidthDefault = 24;
  localparam int QueueDepthDefault = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  pixel_value;
    logic [9:0]  run_length;
    logic [9:0]  written_length;
    logic [23:0] start_position;
    logic        is_final;
    logic [23:0] total_pixels;
    logic [23:0] bytes_consumed;
    logic        stop_cause;
  } out_item_t;

  // Request from the bit decoder to the run emitter.
  typedef struct packed {
    logic       is_final;
    logic       stop_cause;
    logic [7:0] pixel_value;
    logic [9:0] run_length;
    logic [31:0] consumed;
  } req_t;

  typedef enum logic [11:0] {
    PH_ONES   = 12'b000000000001,
    PH_SMALL1 = 12'b000000000010,
    PH_SMALL2 = 12'b000000000100,
    PH_SIGN   = 12'b000000001000,
    PH_DFIELD = 12'b000000010000,
    PH_RTOP_A = 12'b000000100000,
    PH_RTOP_B = 12'b000001000000,
    PH_RSEL   = 12'b000010000000,
    PH_R3_A   = 12'b000100000000,
    PH_R3_B   = 12'b001000000000,
    PH_RFIELD = 12'b010000000000,
    PH_HALT   = 12'b100000000000
  } phase_t;

  localparam logic [7:0] PixelOffset = 8'd19;

  function automatic logic [7:0] backdrop(input logic [15:0] lv);
    logic [7:0] v;
    v = 8'd0;
    case (lv)
      16'hFFF6: v = 8'd7;
      16'hFFF7: v = 8'd6;
      16'hFFF8: v = 8'd5;
      16'hFFF9: v = 8'd8;
      16'hFFFA: v = 8'd9;
      16'hFFFB: v = 8'd4;
      16'hFFFC: v = 8'd3;
      16'hFFFD: v = 8'd0;
      16'hFFFE: v = 8'd2;
      16'hFFFF: v = 8'd1;
      default:  v = 8'd0;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/diff_run_image_decoder_top.sv =====
// Differential run image decoder, top level.
// Depends on drid_pkg, drid_front, drid_queue, drid_back and the defines header.
//
// Usage: compressed bytes enter on the input channel (valid_in, stall_in,
// item_in); each carries eight code bits, read least significant first.
// The front end decodes one code bit per cycle unless a request waits on
// a full queue; a byte that is the last of a block keeps it busy past its
// eighth bit while a code cut short is completed with zero bits and the
// final report is issued. The byte rate is set by the bit-serial decoder
// loop. Bytes arriving after a long-prefix stop are taken and dropped
// until the last byte of the block.
// Run records and final reports leave through valid, stall and result. A
// request passes a four-entry queue and then the output register. When
// the receiver stalls, the output register holds, the queue fills, and
// only then does the decoder pause on the bit that needs a request;
// stall_in is high while a byte is in work, except in the cycle that
// decodes the eighth bit of a byte that neither ends nor stops the block,
// when the next byte is taken so that bytes follow with no idle cycle.
// Reset (rst, synchronous) clears all decode state and sets out_limit to
// 16777215; a final report clears the block state except out_limit, which
// is written through cfg_we and cfg_data.
`default_nettype none
`include "diff_run_image_decoder_top_defines.svh"
module diff_run_image_decoder_top #(
  parameter int CountWidth = drid_pkg::CountWidthDefault,
  parameter int QueueDepth = drid_pkg::QueueDepthDefault
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [23:0]          cfg_data,
  input  wire logic                 valid_in,
  output logic                      stall_in,
  input  wire drid_pkg::in_item_t   item_in,
  output logic                      valid,
  input  wire logic                 stall,
  output drid_pkg::out_item_t       result
);
  import drid_pkg::*;

  logic [23:0] out_limit;
  logic        req_valid;
  logic        req_full;
  req_t        req;
  logic        blk_clear;
  logic        q_avail;
  logic        q_pop;
  req_t        q_head;

  always_ff @(posedge clk) begin
    if (rst) out_limit <= 24'hFFFFFF;
    else if (cfg_we) out_limit <= cfg_data;
  end

  drid_front #(.CountWidth(CountWidth)) u_front (
    .clk, .rst, .valid_in, .stall_in, .item_in,
    .req_valid, .req_full, .req, .blk_clear
  );

  drid_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst, .push(req_valid), .push_data(req), .full(req_full),
    .pop(q_pop), .not_empty(q_avail), .head(q_head)
  );

  drid_back #(.CountWidth(CountWidth)) u_back (
    .clk, .rst, .out_limit, .req_avail(q_avail), .req(q_head), .req_pop(q_pop),
    .valid, .stall, .result
  );

  // A block end after the zero fill must always carry a final request into the queue.
  `DRID_ASSERT_IMP(a_clear_final, blk_clear, req_valid && req.is_final, "block end without final")
  // Nothing is pushed into a full queue.
  `DRID_ASSERT_IMP(a_no_overflow, req_valid, !req_full, "push into full queue")
  // A record written in never exceeds its run length.
  `DRID_ASSERT_IMP(a_wl_bound, valid, result.written_length <= result.run_length, "written too long")
endmodule
`default_nettype wire

// ===== rtl/drid_front.sv =====
// Bit-serial front end: takes bytes, decodes one code bit per cycle as
// queue space allows, issues run and final requests. Depends on drid_pkg.
`default_nettype none
module drid_front #(
  parameter int CountWidth = drid_pkg::CountWidthDefault
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              valid_in,
  output logic                   stall_in,
  input  wire drid_pkg::in_item_t item_in,
  output logic                   req_valid,
  input  wire logic              req_full,
  output drid_pkg::req_t         req,
  output logic                   blk_clear
);
  import drid_pkg::*;
  localparam logic [CountWidth-1:0] CountMax = '1;

  // Byte being worked on.
  logic        busy;
  logic [7:0]  bit_holder;
  logic        last;
  logic [2:0]  bit_idx;
  logic        flush;
  logic [5:0]  guard;

  phase_t      decode_phase;
  logic [3:0]  ones_count;
  logic        sign_flag;
  logic [9:0]  field_value;
  logic [3:0]  field_bits_left;
  logic [15:0] current_level;
  logic [CountWidth-1:0] byte_count;
  logic [CountWidth-1:0] byte_inc;

  logic        b;
  logic        step;
  logic        byte_end;
  logic        need_req;
  logic        take_diff;
  logic        esc;
  logic signed [16:0] diff;
  logic [15:0] new_level;
  logic        f_done;
  logic [9:0]  f_val;
  logic [10:0] run_len;

  // The next byte is taken at the edge that finishes the eighth bit of a
  // byte that neither ends the block nor stops it.
  assign byte_end = step && !flush && !last && bit_idx == 3'd7 &&
                    !(decode_phase == PH_SIGN && ones_count > 4'd7);
  assign stall_in = busy && !byte_end;
  assign b = flush ? 1'b0 : bit_holder[bit_idx];
  assign byte_inc = (byte_count == CountMax) ? byte_count
                                             : byte_count + CountWidth'(1);

  always_comb begin
    f_val  = field_value;
    f_done = 1'b1;
    if (field_bits_left != 4'd0 && field_bits_left <= ones_count) begin
      f_val  = field_value | (10'(b) << (ones_count - field_bits_left));
      f_done = (field_bits_left == 4'd1);
    end
    run_len = (11'd1 << ones_count) + 11'(f_val);
  end

  // Difference from the current code bit, when this bit completes one.
  always_comb begin
    take_diff = 1'b0;
    diff      = '0;
    case (decode_phase)
      PH_SMALL1: begin take_diff = !b; diff = '0; end
      PH_SMALL2: begin take_diff = 1'b1; diff = b ? -17'sd1 : 17'sd1; end
      PH_SIGN:   begin take_diff = (ones_count == 4'd0); diff = '0; end
      PH_DFIELD: begin
        take_diff = f_done;
        diff = 17'((11'd1 << ones_count[2:0]) + 11'(f_val));
        if (sign_flag) diff = -diff;
      end
      default: ;
    endcase
    // The escape is decided on the coded difference, before the raise.
    esc = (diff == -17'sd4);
    if (diff < -17'sd4) diff = diff + 17'sd1;
    new_level = current_level + diff[15:0];
  end

  // Request needed by this step (one at most per bit).
  logic       sel_run;
  logic [9:0] sel_len;
  always_comb begin
    need_req = 1'b0;
    req = '0;
    sel_run = 1'b0;
    sel_len = 10'd1;
    if (flush && (decode_phase == PH_ONES || decode_phase == PH_SMALL1 ||
                  guard == 6'd40)) begin
      need_req = 1'b1;
      req.is_final = 1'b1;
      req.consumed = 32'(byte_count);
    end else if (decode_phase == PH_SIGN && ones_count > 4'd7) begin
      need_req = 1'b1;
      req.is_final = 1'b1;
      req.stop_cause = 1'b1;
      req.consumed = (flush || bit_idx != 3'd7) ? 32'(byte_count) : 32'(byte_inc);
    end else if (take_diff && !esc && !new_level[15]) begin
      need_req = 1'b1;
      req.pixel_value = (new_level == 16'd0) ? 8'd0 : new_level[7:0] + PixelOffset;
      req.run_length = 10'd1;
    end else if (decode_phase == PH_RTOP_B && !field_value[0] && !b) begin
      sel_run = 1'b1;
    end else if (decode_phase == PH_RFIELD && f_done) begin
      sel_run = 1'b1;
      sel_len = run_len[9:0];
    end
    if (sel_run) begin
      need_req = 1'b1;
      req.pixel_value = backdrop(current_level);
      req.run_length = sel_len;
    end
  end

  assign step = busy && !(need_req && req_full);
  assign req_valid = busy && need_req && !req_full;
  assign blk_clear = step && flush && req.is_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; flush <= 1'b0; bit_idx <= '0; guard <= '0;
      decode_phase <= PH_ONES; ones_count <= '0; sign_flag <= 1'b0;
      field_value <= '0; field_bits_left <= '0; current_level <= '0;
      byte_count <= '0; bit_holder <= '0; last <= 1'b0;
    end else if (!busy) begin
      if (valid_in) begin
        if (decode_phase == PH_HALT) begin
          if (item_in.last_byte) begin
            decode_phase <= PH_ONES; ones_count <= '0; sign_flag <= 1'b0;
            field_value <= '0; field_bits_left <= '0; current_level <= '0;
            byte_count <= '0;
          end
        end else begin
          busy <= 1'b1;
          bit_holder <= item_in.in_byte;
          last <= item_in.last_byte;
          bit_idx <= '0;
        end
      end
    end else if (step) begin
      if (flush && req.is_final) begin
        busy <= 1'b0; flush <= 1'b0; guard <= '0;
        decode_phase <= PH_ONES; ones_count <= '0; sign_flag <= 1'b0;
        field_value <= '0; field_bits_left <= '0; current_level <= '0;
        byte_count <= '0;
      end else begin
        if (flush) guard <= guard + 6'd1;
        case (decode_phase)
          PH_ONES: begin
            if (b) begin
              if (ones_count < 4'd8) ones_count <= ones_count + 4'd1;
            end else begin
              decode_phase <= (ones_count == 4'd0) ? PH_SMALL1 : PH_SIGN;
            end
          end
          PH_SMALL1: if (b) decode_phase <= PH_SMALL2;
          PH_SIGN: begin
            sign_flag <= b;
            if (ones_count > 4'd7) begin
              decode_phase <= PH_HALT;
            end else if (ones_count != 4'd0) begin
              field_value <= '0;
              field_bits_left <= ones_count;
              decode_phase <= PH_DFIELD;
            end
          end
          PH_DFIELD: begin
            field_value <= f_val;
            if (field_bits_left != 4'd0 && field_bits_left <= ones_count)
              field_bits_left <= field_bits_left - 4'd1;
          end
          PH_RTOP_A: begin field_value <= 10'(b); decode_phase <= PH_RTOP_B; end
          PH_RTOP_B: begin
            case ({b, field_value[0]})
              2'd0: begin decode_phase <= PH_ONES; ones_count <= '0; end
              2'd1: begin ones_count <= 4'd1; decode_phase <= PH_RSEL; end
              2'd2: begin ones_count <= 4'd3; decode_phase <= PH_RSEL; end
              default: decode_phase <= PH_R3_A;
            endcase
          end
          PH_RSEL: begin
            ones_count <= ones_count + 4'(b);
            field_bits_left <= ones_count + 4'(b);
            field_value <= '0;
            decode_phase <= PH_RFIELD;
          end
          PH_R3_A: begin field_value <= 10'(b); decode_phase <= PH_R3_B; end
          PH_R3_B: begin
            if (b && field_value[0]) begin
              ones_count <= 4'd8; decode_phase <= PH_RSEL;
            end else begin
              ones_count <= 4'd5 + 4'({b, field_value[0]});
              field_bits_left <= 4'd5 + 4'({b, field_value[0]});
              field_value <= '0;
              decode_phase <= PH_RFIELD;
            end
          end
          PH_RFIELD: begin
            field_value <= f_val;
            if (field_bits_left != 4'd0 && field_bits_left <= ones_count)
              field_bits_left <= field_bits_left - 4'd1;
            if (f_done) begin decode_phase <= PH_ONES; ones_count <= '0; end
          end
          default: ;
        endcase
        if (take_diff) begin
          decode_phase <= PH_ONES;
          ones_count <= '0;
          if (esc) begin
            current_level <= '0;
            field_value <= '0;
            decode_phase <= PH_RTOP_A;
          end else begin
            current_level <= new_level;
            if (new_level[15]) begin
              field_value <= '0;
              decode_phase <= PH_RTOP_A;
            end
          end
        end
        // Byte bookkeeping.
        if (decode_phase == PH_SIGN && ones_count > 4'd7) begin
          if (flush) begin
            busy <= 1'b0; flush <= 1'b0; guard <= '0;
          end else begin
            busy <= 1'b0;
            byte_count <= byte_inc;
            if (last) begin
              decode_phase <= PH_ONES; ones_count <= '0; sign_flag <= 1'b0;
              field_value <= '0; field_bits_left <= '0; current_level <= '0;
              byte_count <= '0;
            end
          end
        end else if (!flush && bit_idx == 3'd7) begin
          byte_count <= byte_inc;
          if (last) flush <= 1'b1;
          else if (valid_in) begin
            bit_holder <= item_in.in_byte;
            last <= item_in.last_byte;
            bit_idx <= '0;
          end else busy <= 1'b0;
        end else if (!flush) begin
          bit_idx <= bit_idx + 3'd1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/drid_queue.sv =====
// Small request queue between the bit decoder and the run emitter.
// Depends on drid_pkg.
`default_nettype none
module drid_queue #(
  parameter int Depth = drid_pkg::QueueDepthDefault
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire drid_pkg::req_t push_data,
  output logic                full,
  input  wire logic           pop,
  output logic                not_empty,
  output drid_pkg::req_t      head
);
  import drid_pkg::*;
  localparam int AW = $clog2(Depth);

  req_t            mem [Depth];
  logic [AW-1:0]   wp;
  logic [AW-1:0]   rp;
  logic [AW:0]     cnt;

  assign full = (cnt == (AW+1)'(Depth));
  assign not_empty = (cnt != '0);
  assign head = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= (wp == AW'(Depth - 1)) ? '0 : wp + AW'(1);
      if (pop) rp <= (rp == AW'(Depth - 1)) ? '0 : rp + AW'(1);
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/drid_back.sv =====
// Back end: turns requests into run records and final reports, tracks the
// pixel position and drives the output register. Depends on drid_pkg.
`default_nettype none
module drid_back #(
  parameter int CountWidth = drid_pkg::CountWidthDefault
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [23:0]     out_limit,
  input  wire logic            req_avail,
  input  wire drid_pkg::req_t  req,
  output logic                 req_pop,
  output logic                 valid,
  input  wire logic            stall,
  output drid_pkg::out_item_t  result
);
  import drid_pkg::*;
  localparam logic [CountWidth:0] CountMax = {1'b0, {CountWidth{1'b1}}};

  logic [CountWidth-1:0] pixel_count;
  logic [CountWidth:0]   sum;
  logic [CountWidth:0]   room;
  logic [9:0]            wl;
  out_item_t             rec;

  function automatic logic [23:0] clamp(input logic [CountWidth+8:0] v);
    return (v > (CountWidth+9)'(24'hFFFFFF)) ? 24'hFFFFFF : v[23:0];
  endfunction

  always_comb begin
    sum  = {1'b0, pixel_count} + (CountWidth+1)'(req.run_length);
    room = (CountWidth+1)'(out_limit) - {1'b0, pixel_count};
    wl = 10'd0;
    if ((CountWidth+1)'(out_limit) > {1'b0, pixel_count})
      wl = (room > (CountWidth+1)'(req.run_length)) ? req.run_length : room[9:0];
    rec = '0;
    if (req.is_final) begin
      rec.is_final = 1'b1;
      rec.stop_cause = req.stop_cause;
      rec.total_pixels = clamp((CountWidth+9)'(pixel_count));
      rec.bytes_consumed = (req.consumed > 32'hFFFFFF) ? 24'hFFFFFF : req.consumed[23:0];
    end else begin
      rec.pixel_value = req.pixel_value;
      rec.run_length = req.run_length;
      rec.written_length = wl;
      rec.start_position = clamp((CountWidth+9)'(pixel_count));
    end
  end

  assign req_pop = req_avail && (!valid || !stall);

  always_ff @(posedge clk) begin
    if (req_pop) result <= rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      pixel_count <= '0;
    end else begin
      if (req_pop) valid <= 1'b1;
      else if (!stall) valid <= 1'b0;
      if (req_pop) begin
        if (req.is_final) pixel_count <= '0;
        else pixel_count <= (sum > CountMax) ? CountMax[CountWidth-1:0]
                                              : sum[CountWidth-1:0];
      end
    end
  end
endmodule
`default_nettype wire

// ===== verif/diff_run_image_decoder_top_tb.sv =====
// Self-checking testbench for the differential run image decoder top level.
// Depends on drid_pkg and diff_run_image_decoder_top; it predicts every run
// record and final report in software and compares each one as a whole.
`default_nettype none
module diff_run_image_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import drid_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam logic [23:0] Max24 = 24'hFFFFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [23:0] cfg_data = '0;
  logic valid_in = 1'b0;
  logic stall_in;
  in_item_t item_in = '0;
  logic valid;
  logic stall = 1'b0;
  out_item_t result;

  always #1 clk = ~clk;

  diff_run_image_decoder_top u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .valid_in(valid_in), .stall_in(stall_in), .item_in(item_in),
    .valid(valid), .stall(stall), .result(result)
  );

  // Predicted decoder state, kept as the decoder would keep it.
  phase_t ph;
  logic [23:0] lim;
  logic [3:0] ones;
  logic sgn;
  logic [9:0] fval;
  logic [3:0] fleft;
  logic [15:0] level;
  logic [23:0] pix_total;
  logic [23:0] byte_total;

  out_item_t pending_records[$];
  int errors = 0;
  int idle_pct = 15;
  int quiet_cycles = 0;
  bit halted_hit;
  const logic [7:0] backdrop_tab[10] = '{7, 6, 5, 8, 9, 4, 3, 0, 2, 1};

  function automatic logic [23:0] sat24(input logic [23:0] v, input int n);
    logic [24:0] s;
    s = {1'b0, v} + 25'(n);
    return s > {1'b0, Max24} ? Max24 : s[23:0];
  endfunction

  task automatic clear_block();
    ph = PH_ONES; ones = '0; sgn = 1'b0; fval = '0; fleft = '0;
    level = '0; pix_total = '0; byte_total = '0;
  endtask

  function automatic void push_run(input logic [7:0] v, input int len);
    out_item_t r;
    int wl;
    r = '0;
    wl = 0;
    if (pix_total < lim) begin
      wl = lim - pix_total;
      if (wl > len) wl = len;
    end
    r.pixel_value = v;
    r.run_length = 10'(len);
    r.written_length = 10'(wl);
    r.start_position = pix_total;
    pending_records.push_back(r);
    pix_total = sat24(pix_total, len);
  endfunction

  task automatic push_final(input logic cause, input logic [23:0] consumed);
    out_item_t r;
    r = '0;
    r.is_final = 1'b1;
    r.total_pixels = pix_total;
    r.bytes_consumed = consumed;
    r.stop_cause = cause;
    pending_records.push_back(r);
  endtask

  function automatic void close_run(input int len);
    int lv;
    logic [7:0] v;
    lv = $signed(level);
    v = (lv < 0 && lv >= -10) ? backdrop_tab[lv + 10] : 8'd0;
    ph = PH_ONES;
    ones = '0;
    push_run(v, len);
  endfunction

  function automatic void open_field(input int w);
    ones = 4'(w);
    fleft = ones;
    fval = '0;
    ph = PH_RFIELD;
  endfunction

  // Applies one signed difference to the level.
  function automatic void apply_diff(input int d);
    int lv;
    ph = PH_ONES;
    ones = '0;
    if (d == -4) begin
      level = '0;
      ph = PH_RTOP_A;
      fval = '0;
    end else begin
      if (d < -4) d++;
      level = level + 16'(d);
      lv = $signed(level);
      if (lv == 0) push_run(8'd0, 1);
      else if (lv > 0) push_run(8'(lv + 19), 1);
      else begin
        ph = PH_RTOP_A;
        fval = '0;
      end
    end
  endfunction

  // Adds one bit to a multi-bit field; returns 1 when it is complete.
  function automatic bit field_take(input logic b);
    if (fleft == 0 || fleft > ones) return 1'b1;
    fval = fval | (10'(b) << (ones - fleft));
    fleft--;
    return fleft == 0;
  endfunction

  // Decodes one code bit; returns 1 on a stop for a too-long prefix.
  function automatic bit decode_bit(input logic b);
    logic [1:0] v;
    case (ph)
      PH_ONES: begin
        if (b) begin
          if (ones < 8) ones++;
        end else ph = (ones == 0) ? PH_SMALL1 : PH_SIGN;
      end
      PH_SMALL1: begin
        if (b) ph = PH_SMALL2;
        else apply_diff(0);
      end
      PH_SMALL2: apply_diff(b ? -1 : 1);
      PH_SIGN: begin
        sgn = b;
        if (ones > 7) begin
          ph = PH_HALT;
          return 1'b1;
        end
        fval = '0;
        fleft = ones;
        ph = PH_DFIELD;
      end
      PH_DFIELD: begin
        if (field_take(b)) apply_diff(sgn ? -((1 << ones[2:0]) + fval)
                                          : (1 << ones[2:0]) + fval);
      end
      PH_RTOP_A: begin
        fval = 10'(b);
        ph = PH_RTOP_B;
      end
      PH_RTOP_B: begin
        v = {b, fval[0]};
        if (v == 0) close_run(1);
        else if (v == 1) begin
          ones = 1; ph = PH_RSEL;
        end else if (v == 2) begin
          ones = 3; ph = PH_RSEL;
        end else ph = PH_R3_A;
      end
      PH_RSEL: open_field(ones + b);
      PH_R3_A: begin
        fval = 10'(b);
        ph = PH_R3_B;
      end
      PH_R3_B: begin
        v = {b, fval[0]};
        if (v == 3) begin
          ones = 8; ph = PH_RSEL;
        end else open_field(5 + v);
      end
      PH_RFIELD: if (field_take(b)) close_run((1 << ones) + fval);
      default: ;
    endcase
    return 1'b0;
  endfunction

  // Predicts the records caused by one compressed byte.
  task automatic predict_byte(input in_item_t it);
    int i;
    if (ph == PH_HALT) begin
      if (it.last_byte) clear_block();
      return;
    end
    halted_hit = 1'b0;
    for (i = 0; i < 8; i++) begin
      if (decode_bit(it.in_byte[i])) begin
        push_final(1'b1, sat24(byte_total, i == 7 ? 1 : 0));
        halted_hit = 1'b1;
        break;
      end
    end
    byte_total = sat24(byte_total, 1);
    if (halted_hit) begin
      if (it.last_byte) clear_block();
      return;
    end
    if (it.last_byte) begin
      for (i = 0; i < 40; i++) begin
        if (ph == PH_ONES || ph == PH_HALT) break;
        if (ph == PH_SMALL1) begin
          ph = PH_ONES;
          break;
        end
        if (decode_bit(1'b0)) begin
          push_final(1'b1, byte_total);
          halted_hit = 1'b1;
          break;
        end
      end
      if (!halted_hit) push_final(1'b0, byte_total);
      clear_block();
    end
  endtask

  // Sends one request and holds it until the decoder takes it. Valid stays
  // high into the next call so that requests can follow back to back.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      valid_in <= 1'b0;
      @(negedge clk);
    end
    valid_in <= 1'b1;
    item_in <= '{in_byte: b, last_byte: last};
    @(posedge clk);
    while (stall_in) @(posedge clk);
    predict_byte('{in_byte: b, last_byte: last});
    @(negedge clk);
  endtask

  // Waits until every predicted record has arrived, then lets the tail settle.
  task automatic drain();
    valid_in <= 1'b0;
    while (pending_records.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_limit(input logic [23:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    lim = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Receiver: random stall, compare every accepted record with the oldest one.
  always @(negedge clk) stall <= ($urandom_range(99) < idle_pct);

  always @(posedge clk) begin
    if (!rst && valid && !stall) begin
      if (pending_records.size() == 0) begin
        $display("%0t: unexpected record %p", $time, result);
        errors++;
      end else begin
        if (result !== pending_records[0]) begin
          $display("%0t: record mismatch expected %p actual %p", $time,
                   pending_records[0], result);
          errors++;
        end
        void'(pending_records.pop_front());
      end
    end
  end

  // Watchdog on cycles without any accepted request or record.
  always @(posedge clk) begin
    if (rst || (valid_in && !stall_in) || (valid && !stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("diff_run_image_decoder_top test failed");
      $finish;
    end
  end

  // Small codes, differences of several widths, the escape to runs and
  // background levels of several run width classes.
  task automatic test_directed();
    send_byte(8'h00, 1'b0);
    send_byte(8'b0110_1010, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'b1110_0111, 1'b0);
    send_byte(8'hFF, 1'b1);
    // A long ones prefix stops the block; later bytes are ignored.
    send_byte(8'hFF, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h12, 1'b1);
    // A code cut short inside a ones prefix at the end of data.
    send_byte(8'b0001_1111, 1'b0);
    send_byte(8'hF3, 1'b1);
    // A lone trailing zero and a too-long prefix ended inside the last byte.
    send_byte(8'h00, 1'b1);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h01, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFE, 1'b1);
  endtask

  // Random blocks, mostly made of short, well-formed codes.
  task automatic test_random(input int n_bytes);
    int k;
    logic [7:0] b;
    for (k = 0; k < n_bytes; k++) begin
      case ($urandom_range(3))
        0: b = 8'($urandom);
        1: b = 8'($urandom) & 8'h77;
        2: b = 8'($urandom) & 8'h3B;
        default: b = 8'($urandom) | 8'h0C;
      endcase
      send_byte(b, $urandom_range(11) == 0 || k == n_bytes - 1);
    end
  endtask

  // The sender waits for every record before going on.
  task automatic test_pause();
    test_random(6);
    drain();
    test_random(6);
  endtask

  task automatic test_limits();
    write_limit(24'd0);
    test_random(30);
    write_limit(24'd3);
    test_random(30);
    write_limit(24'($urandom_range(40, 1)));
    test_random(30);
    write_limit(Max24);
  endtask

  initial begin
    lim = Max24;
    clear_block();
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_pause();
    test_limits();
    // A long stretch without idling on either side.
    idle_pct = 0;
    test_random(40);
    idle_pct = 15;
    test_random(20);
    drain();
    if (errors == 0 && pending_records.size() == 0)
      $display("diff_run_image_decoder_top test passed");
    else
      $display("diff_run_image_decoder_top test failed");
    $finish;
  end
endmodule
`default_nettype wire
